>>> sv/hrhp_pkg.sv
// Shared types, constants and character tables of the HTTP response header parser.
// Depends on nothing; every other file refers to it by scoped names.
package hrhp_pkg;

  // Width of the content-length accumulator; values saturate at 2^LENGTH_BITS-1.
  localparam int LENGTH_BITS = 32;
  localparam int ACC_EXT_W   = LENGTH_BITS + 4;

  typedef enum logic [3:0] {
    PH_VERSION  = 4'd0,
    PH_STATUS   = 4'd1,
    PH_HEADERS  = 4'd2,
    PH_NAME     = 4'd3,
    PH_LENGTH   = 4'd4,
    PH_TYPE     = 4'd5,
    PH_ENCODING = 4'd6,
    PH_LINEEND  = 4'd7,
    PH_DONE     = 4'd8,
    PH_ERROR    = 4'd9
  } phase_t;

  // Line-end tracker codes
  localparam logic [2:0] SEQ_IDLE   = 3'd0;
  localparam logic [2:0] SEQ_CR     = 3'd1;
  localparam logic [2:0] SEQ_CRLF   = 3'd2;
  localparam logic [2:0] SEQ_CRLFCR = 3'd3;
  localparam logic [2:0] SEQ_END    = 3'd4;
  localparam logic [2:0] SEQ_BROKEN = 3'd7;

  // Characters
  localparam logic [7:0] CH_SP      = 8'h20;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_C = 8'h63;
  localparam logic [7:0] CH_LOWER_T = 8'h74;
  localparam logic [7:0] CASE_BIT   = 8'h20;

  // Header names, index order is the bit order of the alive mask
  localparam int NUM_HDR = 3;
  localparam logic [1:0] HDR_LENGTH   = 2'd0;
  localparam logic [1:0] HDR_TYPE     = 2'd1;
  localparam logic [1:0] HDR_ENCODING = 2'd2;

  localparam int HDR_LEN_LENGTH   = 14;
  localparam int HDR_LEN_TYPE     = 12;
  localparam int HDR_LEN_ENCODING = 17;

  localparam logic [8*HDR_LEN_LENGTH-1:0]   STR_LENGTH   = "content-length";
  localparam logic [8*HDR_LEN_TYPE-1:0]     STR_TYPE     = "content-type";
  localparam logic [8*HDR_LEN_ENCODING-1:0] STR_ENCODING = "transfer-encoding";

  localparam int WORD_LEN = 7;
  localparam logic [8*WORD_LEN-1:0] STR_CHUNKED = "chunked";

  localparam logic [15:0] STATUS_MAX = 16'hFFFF;
  localparam logic [LENGTH_BITS-1:0] LENGTH_MAX = {LENGTH_BITS{1'b1}};

  typedef struct packed {
    logic [4:0]         count;
    logic [NUM_HDR-1:0] alive;
  } name_state_t;

  function automatic logic [4:0] hdr_len(input logic [1:0] k);
    logic [4:0] n;
    case (k)
      HDR_LENGTH:   n = 5'(HDR_LEN_LENGTH);
      HDR_TYPE:     n = 5'(HDR_LEN_TYPE);
      HDR_ENCODING: n = 5'(HDR_LEN_ENCODING);
      default:      n = 5'd0;
    endcase
    return n;
  endfunction

  // Character of header name k at position pos; zero beyond the name.
  function automatic logic [7:0] hdr_char(input logic [1:0] k, input logic [4:0] pos);
    logic [7:0] c;
    c = 8'h00;
    case (k)
      HDR_LENGTH: begin
        if (pos < 5'(HDR_LEN_LENGTH))
          c = STR_LENGTH[8*(HDR_LEN_LENGTH-1-int'(pos)) +: 8];
      end
      HDR_TYPE: begin
        if (pos < 5'(HDR_LEN_TYPE))
          c = STR_TYPE[8*(HDR_LEN_TYPE-1-int'(pos)) +: 8];
      end
      HDR_ENCODING: begin
        if (pos < 5'(HDR_LEN_ENCODING))
          c = STR_ENCODING[8*(HDR_LEN_ENCODING-1-int'(pos)) +: 8];
      end
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] chunk_char(input logic [2:0] pos);
    logic [7:0] c;
    c = 8'h00;
    if (pos < 3'(WORD_LEN))
      c = STR_CHUNKED[8*(WORD_LEN-1-int'(pos)) +: 8];
    return c;
  endfunction

endpackage

>>> sv/hrhp_num_acc.sv
// Saturating decimal accumulator step: acc*10 + digit, clamped to a selected limit.
// Depends on hrhp_pkg.
module hrhp_num_acc (
  input  logic [7:0]                      byte_lc,
  input  logic                            sel_length,
  input  logic [hrhp_pkg::LENGTH_BITS-1:0] acc,
  input  logic                            stopped,
  output logic [hrhp_pkg::LENGTH_BITS-1:0] acc_nxt,
  output logic                            stopped_nxt
);

  logic                            is_digit;
  logic [hrhp_pkg::ACC_EXT_W-1:0] acc_ext;
  logic [hrhp_pkg::ACC_EXT_W-1:0] sum;
  logic [hrhp_pkg::ACC_EXT_W-1:0] limit;

  assign is_digit = (byte_lc >= hrhp_pkg::CH_ZERO) && (byte_lc <= hrhp_pkg::CH_NINE);
  assign acc_ext  = hrhp_pkg::ACC_EXT_W'(acc);
  // acc*10 as shift-and-add, then the digit value
  assign sum      = (acc_ext << 3) + (acc_ext << 1)
                  + hrhp_pkg::ACC_EXT_W'(byte_lc - hrhp_pkg::CH_ZERO);
  assign limit    = sel_length ? hrhp_pkg::ACC_EXT_W'(hrhp_pkg::LENGTH_MAX)
                               : hrhp_pkg::ACC_EXT_W'(hrhp_pkg::STATUS_MAX);

  always_comb begin
    acc_nxt     = acc;
    stopped_nxt = stopped;
    if (!stopped) begin
      if (!is_digit) begin
        stopped_nxt = 1'b1;
      end else if (sum > limit) begin
        acc_nxt = limit[hrhp_pkg::LENGTH_BITS-1:0];
      end else begin
        acc_nxt = sum[hrhp_pkg::LENGTH_BITS-1:0];
      end
    end
  end

endmodule

>>> sv/hrhp_name_match.sv
// Header-name matcher: start, per-byte narrowing and final selection on the colon.
// Depends on hrhp_pkg.
module hrhp_name_match (
  input  logic [7:0]                  byte_lc,
  input  hrhp_pkg::name_state_t       cur,
  output hrhp_pkg::name_state_t       start_st,
  output hrhp_pkg::name_state_t       step_st,
  output hrhp_pkg::phase_t            hit_phase
);

  always_comb begin
    start_st.count = 5'd1;
    start_st.alive = '0;
    step_st.count  = (cur.count != 5'd31) ? cur.count + 5'd1 : cur.count;
    step_st.alive  = cur.alive;
    for (int k = 0; k < hrhp_pkg::NUM_HDR; k++) begin
      if (hrhp_pkg::hdr_char(2'(k), 5'd0) == byte_lc)
        start_st.alive[k] = 1'b1;
      // drop a candidate on a mismatch or once past its length
      if (!((cur.count < hrhp_pkg::hdr_len(2'(k)))
            && (hrhp_pkg::hdr_char(2'(k), cur.count) == byte_lc)))
        step_st.alive[k] = 1'b0;
    end
  end

  always_comb begin
    if (cur.alive[hrhp_pkg::HDR_LENGTH]
        && cur.count == hrhp_pkg::hdr_len(hrhp_pkg::HDR_LENGTH))
      hit_phase = hrhp_pkg::PH_LENGTH;
    else if (cur.alive[hrhp_pkg::HDR_TYPE]
        && cur.count == hrhp_pkg::hdr_len(hrhp_pkg::HDR_TYPE))
      hit_phase = hrhp_pkg::PH_TYPE;
    else if (cur.alive[hrhp_pkg::HDR_ENCODING]
        && cur.count == hrhp_pkg::hdr_len(hrhp_pkg::HDR_ENCODING))
      hit_phase = hrhp_pkg::PH_ENCODING;
    else
      hit_phase = hrhp_pkg::PH_HEADERS;
  end

endmodule

>>> sv/http_response_header_parser_unit.sv
// Top level of the HTTP response header parser: input register, phase machine, result register.
// Depends on hrhp_pkg, hrhp_num_acc and hrhp_name_match.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-----------------------------------------
//   in      | input     | in_valid / in_ready  | in_byte_in
//   out     | output    | out_valid/ out_ready | out_phase, out_done_res, out_error,
//           |           |                      | out_status_value, out_content_length,
//           |           |                      | out_chunked, out_media_*
//
// One item per cycle sustained while out_ready stays high; an accepted item passes the
// input register, then its result is written to the result register, from which it is
// taken. The combinational phase machine and its decimal multiply-add step sit between
// the two registers.
// Reset (rst_n low, synchronous) returns the parser to the version phase and
// empties both registers. When out_ready is low the result holds and one more item
// is taken into the input register; after that in_ready drops until the result
// is taken.
module http_response_header_parser_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_phase,
  output logic        out_done_res,
  output logic        out_error,
  output logic [15:0] out_status_value,
  output logic [31:0] out_content_length,
  output logic        out_chunked,
  output logic        out_media_valid,
  output logic [7:0]  out_media_char,
  output logic        out_media_end
);

  // Input stage
  logic [7:0] byte_r;
  logic       byte_vld_r;
  logic       adv;

  // Parser state
  hrhp_pkg::phase_t                 phase_r, phase_nxt;
  hrhp_pkg::name_state_t            name_r, name_nxt;
  logic [hrhp_pkg::LENGTH_BITS-1:0] acc_r, acc_nxt;
  logic                             stop_r, stop_nxt;
  logic [2:0]                       wpos_r, wpos_nxt;
  logic [2:0]                       seq_r, seq_nxt;
  logic [15:0]                      status_r, status_nxt;
  logic [hrhp_pkg::LENGTH_BITS-1:0] length_r, length_nxt;
  logic                             chunked_r, chunked_nxt;

  // Result register
  logic       out_valid_r;
  logic [3:0] out_phase_r;
  logic       out_done_r;
  logic       out_error_r;
  logic [15:0] out_status_r;
  logic [31:0] out_length_r;
  logic       out_chunked_r;
  logic       out_mvalid_r;
  logic [7:0] out_mchar_r;
  logic       out_mend_r;

  // Per-byte combinational results
  logic [7:0]                       b;
  logic                             err;
  logic                             mvalid;
  logic [7:0]                       mchar;
  logic                             mend;
  logic                             clr;
  logic [hrhp_pkg::LENGTH_BITS-1:0] dig_acc;
  logic                             dig_stop;
  hrhp_pkg::name_state_t            nm_start, nm_step;
  hrhp_pkg::phase_t                 nm_hit;

  // Advance the input stage into the result register when the result slot frees up
  assign adv      = byte_vld_r && (!out_valid_r || out_ready);
  assign in_ready = !byte_vld_r || !out_valid_r || out_ready;

  // Lowercase A..Z
  always_comb begin
    b = byte_r;
    if (byte_r inside {[hrhp_pkg::CH_UPPER_A:hrhp_pkg::CH_UPPER_Z]})
      b = byte_r | hrhp_pkg::CASE_BIT;
  end

  hrhp_num_acc u_num_acc (
    .byte_lc     (b),
    .sel_length  (phase_r == hrhp_pkg::PH_LENGTH),
    .acc         (acc_r),
    .stopped     (stop_r),
    .acc_nxt     (dig_acc),
    .stopped_nxt (dig_stop)
  );

  hrhp_name_match u_name_match (
    .byte_lc   (b),
    .cur       (name_r),
    .start_st  (nm_start),
    .step_st   (nm_step),
    .hit_phase (nm_hit)
  );

  // Phase machine: next state and per-item outputs
  always_comb begin
    phase_nxt   = phase_r;
    name_nxt    = name_r;
    acc_nxt     = acc_r;
    stop_nxt    = stop_r;
    wpos_nxt    = wpos_r;
    seq_nxt     = seq_r;
    status_nxt  = status_r;
    length_nxt  = length_r;
    chunked_nxt = chunked_r;
    err         = 1'b0;
    mvalid      = 1'b0;
    mchar       = 8'h00;
    mend        = 1'b0;
    clr         = 1'b0;

    case (phase_r)
      hrhp_pkg::PH_VERSION: begin
        if (b == hrhp_pkg::CH_SP) begin
          clr       = 1'b1;
          phase_nxt = hrhp_pkg::PH_STATUS;
        end
      end
      hrhp_pkg::PH_STATUS: begin
        if (b == hrhp_pkg::CH_SP) begin
          // accumulator is already clamped to the status limit
          status_nxt = acc_r[15:0];
          clr        = 1'b1;
          phase_nxt  = hrhp_pkg::PH_HEADERS;
        end else begin
          acc_nxt  = dig_acc;
          stop_nxt = dig_stop;
        end
      end
      hrhp_pkg::PH_HEADERS: begin
        if (b == hrhp_pkg::CH_CR) begin
          seq_nxt   = hrhp_pkg::SEQ_CR;
          phase_nxt = hrhp_pkg::PH_LINEEND;
        end
      end
      hrhp_pkg::PH_LINEEND: begin
        if (b == hrhp_pkg::CH_LF) begin
          if (seq_r == hrhp_pkg::SEQ_CRLFCR) begin
            seq_nxt   = hrhp_pkg::SEQ_END;
            phase_nxt = hrhp_pkg::PH_DONE;
          end else begin
            seq_nxt = (seq_r == hrhp_pkg::SEQ_CR) ? hrhp_pkg::SEQ_CRLF : hrhp_pkg::SEQ_BROKEN;
          end
        end else if (b == hrhp_pkg::CH_CR) begin
          seq_nxt = (seq_r == hrhp_pkg::SEQ_CRLF) ? hrhp_pkg::SEQ_CRLFCR : hrhp_pkg::SEQ_BROKEN;
        end else if (b == hrhp_pkg::CH_LOWER_T || b == hrhp_pkg::CH_LOWER_C) begin
          name_nxt  = nm_start;
          phase_nxt = hrhp_pkg::PH_NAME;
        end else begin
          phase_nxt = hrhp_pkg::PH_HEADERS;
        end
      end
      hrhp_pkg::PH_NAME: begin
        if (b == hrhp_pkg::CH_COLON) begin
          clr       = 1'b1;
          phase_nxt = nm_hit;
        end else begin
          name_nxt = nm_step;
        end
      end
      hrhp_pkg::PH_LENGTH: begin
        if (b == hrhp_pkg::CH_CR) begin
          length_nxt = acc_r;
          clr        = 1'b1;
          seq_nxt    = hrhp_pkg::SEQ_CR;
          phase_nxt  = hrhp_pkg::PH_LINEEND;
        end else if (b != hrhp_pkg::CH_SP) begin
          acc_nxt  = dig_acc;
          stop_nxt = dig_stop;
        end
      end
      hrhp_pkg::PH_TYPE: begin
        if (b == hrhp_pkg::CH_CR) begin
          mend      = 1'b1;
          seq_nxt   = hrhp_pkg::SEQ_CR;
          phase_nxt = hrhp_pkg::PH_LINEEND;
        end else if (b != hrhp_pkg::CH_SP) begin
          mvalid = 1'b1;
          mchar  = b;
        end
      end
      hrhp_pkg::PH_ENCODING: begin
        if (b == hrhp_pkg::CH_CR) begin
          if (wpos_r >= 3'(hrhp_pkg::WORD_LEN))
            chunked_nxt = 1'b1;
          clr       = 1'b1;
          seq_nxt   = hrhp_pkg::SEQ_CR;
          phase_nxt = hrhp_pkg::PH_LINEEND;
        end else if (b != hrhp_pkg::CH_SP) begin
          // scan for the word; a 'c' restarts the match
          if (wpos_r < 3'(hrhp_pkg::WORD_LEN)) begin
            if (hrhp_pkg::chunk_char(wpos_r) == b)
              wpos_nxt = wpos_r + 3'd1;
            else
              wpos_nxt = (b == hrhp_pkg::CH_LOWER_C) ? 3'd1 : 3'd0;
          end
        end
      end
      default: begin
        // done, error, or any unused code: every further byte is an error
        err       = 1'b1;
        phase_nxt = hrhp_pkg::PH_ERROR;
      end
    endcase

    if (clr) begin
      acc_nxt  = '0;
      stop_nxt = 1'b0;
      wpos_nxt = 3'd0;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_vld_r <= 1'b0;
    end else if (in_ready) begin
      byte_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_byte_in;
    end
  end

  // Parser state: advance once per item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= hrhp_pkg::PH_VERSION;
      name_r.count  <= 5'd0;
      name_r.alive  <= '1;
      acc_r         <= '0;
      stop_r        <= 1'b0;
      wpos_r        <= 3'd0;
      seq_r         <= hrhp_pkg::SEQ_IDLE;
      status_r      <= 16'd0;
      length_r      <= '0;
      chunked_r     <= 1'b0;
    end else if (adv) begin
      phase_r   <= phase_nxt;
      name_r    <= name_nxt;
      acc_r     <= acc_nxt;
      stop_r    <= stop_nxt;
      wpos_r    <= wpos_nxt;
      seq_r     <= seq_nxt;
      status_r  <= status_nxt;
      length_r  <= length_nxt;
      chunked_r <= chunked_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_phase_r   <= phase_nxt;
      out_done_r    <= (phase_nxt >= hrhp_pkg::PH_DONE);
      out_error_r   <= err;
      out_status_r  <= status_nxt;
      out_length_r  <= 32'(length_nxt);
      out_chunked_r <= chunked_nxt;
      out_mvalid_r  <= mvalid;
      out_mchar_r   <= mchar;
      out_mend_r    <= mend;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_phase          = out_phase_r;
  assign out_done_res       = out_done_r;
  assign out_error          = out_error_r;
  assign out_status_value   = out_status_r;
  assign out_content_length = out_length_r;
  assign out_chunked        = out_chunked_r;
  assign out_media_valid    = out_mvalid_r;
  assign out_media_char     = out_mchar_r;
  assign out_media_end      = out_mend_r;

endmodule

>>> tb/sv/tb_http_response_header_parser_unit.sv
// Self-checking testbench for http_response_header_parser_unit: streams response header bytes
// under random idle on both channels and compares every result with an in-bench parser model.
// Depends on hrhp_pkg (phase_t, phase codes, LENGTH_BITS) and the parser RTL; needs nothing else.
module tb_http_response_header_parser_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RESET_CYCLES = 8;
  localparam int TARGET_ITEMS = 1250;
  localparam int TAIL_CYCLES  = 12;
  localparam int HOLDOFF_AT   = 300;   // results seen before the long receiver hold-off
  localparam int HOLDOFF_LEN  = 120;
  localparam int MAX_REPORTS  = 200;

  // Bytes with a role in the parser
  localparam logic [7:0] K_CR    = 8'h0D;
  localparam logic [7:0] K_LF    = 8'h0A;
  localparam logic [7:0] K_SP    = 8'h20;
  localparam logic [7:0] K_COLON = 8'h3A;

  // Line-end tracker of the model
  localparam logic [2:0] LE_CR     = 3'd1;
  localparam logic [2:0] LE_CRLF   = 3'd2;
  localparam logic [2:0] LE_CRLFCR = 3'd3;
  localparam logic [2:0] LE_END    = 3'd4;
  localparam logic [2:0] LE_BAD    = 3'd7;

  // Header indexes, also the bit order of the candidate mask
  localparam int H_LENGTH   = 0;
  localparam int H_TYPE     = 1;
  localparam int H_ENCODING = 2;
  localparam int NUM_HDRS   = 3;
  localparam int CHUNK_LEN  = 7;

  localparam logic [63:0] STATUS_CAP = 64'd65535;
  localparam logic [63:0] LEN_CAP    = (64'd1 << hrhp_pkg::LENGTH_BITS) - 64'd1;

  // Kinds of generated header lines
  localparam int KIND_LENGTH   = 0;
  localparam int KIND_TYPE     = 1;
  localparam int KIND_ENCODING = 2;
  localparam int KIND_NEAR     = 3;
  localparam int KIND_OTHER    = 4;
  localparam int KIND_NOISE    = 5;
  localparam int NUM_KINDS     = 6;

  typedef struct {
    logic [7:0] data;
    bit         pause;   // no byte: hold the sender until every result is back
  } tx_item_t;

  typedef struct packed {
    hrhp_pkg::phase_t phase;
    logic        done_res;
    logic        error;
    logic [15:0] status_value;
    logic [31:0] content_length;
    logic        chunked;
    logic        media_valid;
    logic [7:0]  media_char;
    logic        media_end;
  } parse_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte_in = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  out_phase;
  logic        out_done_res;
  logic        out_error;
  logic [15:0] out_status_value;
  logic [31:0] out_content_length;
  logic        out_chunked;
  logic        out_media_valid;
  logic [7:0]  out_media_char;
  logic        out_media_end;

  tx_item_t      pending[$];        // bytes still to offer, filled once at time zero
  parse_result_t predicted_q[$];    // results owed by the block, oldest first
  int            n_queued = 0;      // bytes put into pending
  int            n_accepted = 0;    // bytes taken by the block
  int            n_checked = 0;     // results taken from the block
  int            n_fail = 0;

  // Parser model state, at its reset values
  hrhp_pkg::phase_t m_phase = hrhp_pkg::PH_VERSION;
  logic [4:0]  m_name_len = 5'd0;
  logic [2:0]  m_name_hits = 3'b111;
  logic [63:0] m_num = 64'd0;
  bit          m_num_done = 1'b0;
  logic [2:0]  m_chunk_pos = 3'd0;
  logic [2:0]  m_crlf = 3'd0;
  logic [15:0] m_status = 16'd0;
  logic [63:0] m_length = 64'd0;
  bit          m_chunked = 1'b0;

  always #5 clk = ~clk;

  http_response_header_parser_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_byte_in         (in_byte_in),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_phase          (out_phase),
    .out_done_res       (out_done_res),
    .out_error          (out_error),
    .out_status_value   (out_status_value),
    .out_content_length (out_content_length),
    .out_chunked        (out_chunked),
    .out_media_valid    (out_media_valid),
    .out_media_char     (out_media_char),
    .out_media_end      (out_media_end)
  );

  // ---------------------------------------------------------------------------------------
  // Parser model
  // ---------------------------------------------------------------------------------------

  function automatic string hdr_text(int k);
    case (k)
      H_LENGTH: return "content-length";
      H_TYPE:   return "content-type";
      default:  return "transfer-encoding";
    endcase
  endfunction

  // Drop the number and word scratch between fields.
  function automatic void restart_scratch();
    m_num       = 64'd0;
    m_num_done  = 1'b0;
    m_chunk_pos = 3'd0;
  endfunction

  function automatic void open_line_end();
    m_crlf  = LE_CR;
    m_phase = hrhp_pkg::PH_LINEEND;
  endfunction

  // Fold one byte into the running decimal value; stop for good at the first non-digit.
  // Saturate as soon as the next step could pass the cap.
  function automatic void accumulate_digit(logic [7:0] c, logic [63:0] cap);
    logic [63:0] d;
    if (m_num_done)
      return;
    if (c < "0" || c > "9") begin
      m_num_done = 1'b1;
      return;
    end
    d = {56'd0, c - 8'h30};
    if (m_num > cap || m_num > (cap - d) / 64'd10)
      m_num = cap;
    else
      m_num = m_num * 64'd10 + d;
  endfunction

  // Advance the model by one byte and return the result that byte produces.
  function automatic parse_result_t parse_byte(logic [7:0] raw);
    logic [7:0]       b;
    parse_result_t    r;
    hrhp_pkg::phase_t nxt;
    string            word;
    b = raw;
    if (b >= "A" && b <= "Z")
      b = b + 8'h20;
    r = '0;
    case (m_phase)
      hrhp_pkg::PH_VERSION: begin
        if (b == K_SP) begin
          restart_scratch();
          m_phase = hrhp_pkg::PH_STATUS;
        end
      end
      hrhp_pkg::PH_STATUS: begin
        if (b == K_SP) begin
          m_status = (m_num > STATUS_CAP) ? 16'hFFFF : m_num[15:0];
          restart_scratch();
          m_phase = hrhp_pkg::PH_HEADERS;
        end else begin
          accumulate_digit(b, STATUS_CAP);
        end
      end
      hrhp_pkg::PH_HEADERS: begin
        if (b == K_CR)
          open_line_end();
      end
      hrhp_pkg::PH_LINEEND: begin
        if (b == K_LF) begin
          if (m_crlf == LE_CRLFCR) begin
            m_crlf  = LE_END;
            m_phase = hrhp_pkg::PH_DONE;
          end else begin
            m_crlf = (m_crlf == LE_CR) ? LE_CRLF : LE_BAD;
          end
        end else if (b == K_CR) begin
          m_crlf = (m_crlf == LE_CRLF) ? LE_CRLFCR : LE_BAD;
        end else if (b == "t" || b == "c") begin
          m_name_len  = 5'd1;
          m_name_hits = 3'b000;
          for (int k = 0; k < NUM_HDRS; k++) begin
            word = hdr_text(k);
            if (word[0] == b)
              m_name_hits[k] = 1'b1;
          end
          m_phase = hrhp_pkg::PH_NAME;
        end else begin
          m_phase = hrhp_pkg::PH_HEADERS;
        end
      end
      hrhp_pkg::PH_NAME: begin
        if (b == K_COLON) begin
          // lowest index wins, though only one length can fit
          nxt = hrhp_pkg::PH_HEADERS;
          for (int k = NUM_HDRS - 1; k >= 0; k--) begin
            word = hdr_text(k);
            if (m_name_hits[k] && m_name_len == word.len()) begin
              case (k)
                H_LENGTH: nxt = hrhp_pkg::PH_LENGTH;
                H_TYPE:   nxt = hrhp_pkg::PH_TYPE;
                default:  nxt = hrhp_pkg::PH_ENCODING;
              endcase
            end
          end
          restart_scratch();
          m_phase = nxt;
        end else begin
          for (int k = 0; k < NUM_HDRS; k++) begin
            word = hdr_text(k);
            if (!(m_name_len < word.len() && word[m_name_len] == b))
              m_name_hits[k] = 1'b0;
          end
          if (m_name_len < 5'd31)
            m_name_len = m_name_len + 5'd1;
        end
      end
      hrhp_pkg::PH_LENGTH: begin
        if (b == K_CR) begin
          m_length = (m_num > LEN_CAP) ? LEN_CAP : m_num;
          restart_scratch();
          open_line_end();
        end else if (b != K_SP) begin
          accumulate_digit(b, LEN_CAP);
        end
      end
      hrhp_pkg::PH_TYPE: begin
        if (b == K_CR) begin
          r.media_end = 1'b1;
          open_line_end();
        end else if (b != K_SP) begin
          r.media_valid = 1'b1;
          r.media_char  = b;
        end
      end
      hrhp_pkg::PH_ENCODING: begin
        if (b == K_CR) begin
          if (m_chunk_pos >= 3'(CHUNK_LEN))
            m_chunked = 1'b1;
          restart_scratch();
          open_line_end();
        end else if (b != K_SP && m_chunk_pos < 3'(CHUNK_LEN)) begin
          word = "chunked";
          if (word[m_chunk_pos] == b)
            m_chunk_pos = m_chunk_pos + 3'd1;
          else
            m_chunk_pos = (b == "c") ? 3'd1 : 3'd0;
        end
      end
      default: begin
        // done or error: every further byte is an error
        r.error = 1'b1;
        m_phase = hrhp_pkg::PH_ERROR;
      end
    endcase
    r.phase          = m_phase;
    r.done_res       = (m_phase >= hrhp_pkg::PH_DONE);
    r.status_value   = m_status;
    r.content_length = m_length[31:0];
    r.chunked        = m_chunked;
    return r;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------------------------

  function automatic void add_byte(logic [7:0] b);
    pending.push_back('{b, 1'b0});
    n_queued++;
  endfunction

  function automatic void add_pause();
    pending.push_back('{8'h00, 1'b1});
  endfunction

  // Push a string, flipping lowercase letters to uppercase at random when asked.
  function automatic void add_text(string s, bit mixed);
    logic [7:0] c;
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      if (mixed && c >= "a" && c <= "z" && $urandom_range(0, 1) == 1)
        c = c - 8'h20;
      add_byte(c);
    end
  endfunction

  function automatic logic [7:0] rand_byte_but(logic [7:0] x, logic [7:0] y);
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while (c == x || c == y)
      c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  // Random value bytes: anything but CR, with spaces made common.
  function automatic void add_junk(int n);
    repeat (n) begin
      if ($urandom_range(0, 4) == 0)
        add_byte(K_SP);
      else
        add_byte(rand_byte_but(K_CR, K_CR));
    end
  endfunction

  // Close a line: mostly a clean CR LF, sometimes a broken order that must not end
  // the header. CR LF CR leaves the next line to start right after it.
  function automatic void add_line_end();
    int pick;
    pick = $urandom_range(0, 19);
    add_byte(K_CR);
    case (pick)
      0: begin add_byte(K_CR); add_byte(K_LF); end
      1: begin add_byte(K_LF); add_byte(K_LF); end
      2: begin add_byte(K_LF); add_byte(K_CR); end
      3: begin add_byte(K_LF); add_byte(K_CR); add_byte(K_CR); add_byte(K_LF); end
      default: add_byte(K_LF);
    endcase
  endfunction

  // One header line. Every line starts with a byte other than CR or LF, and every name
  // carries a colon so that the closing CR lands after the name phase.
  function automatic void add_header_line(int kind);
    int         n;
    logic [7:0] c;
    case (kind)
      KIND_LENGTH: begin
        add_text("content-length", 1'b1);
        add_byte(K_COLON);
        repeat ($urandom_range(0, 2)) add_byte(K_SP);
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 14) : $urandom_range(0, 6);
        repeat (n) begin
          if ($urandom_range(0, 5) == 0)
            add_byte(K_SP);
          add_byte(8'h30 + 8'($urandom_range(0, 9)));
        end
        // trailing junk: digits must stop at its first non-digit
        if ($urandom_range(0, 3) == 0) begin
          add_byte("x");
          add_junk($urandom_range(0, 4));
        end
      end
      KIND_TYPE: begin
        add_text("content-type", 1'b1);
        add_byte(K_COLON);
        if ($urandom_range(0, 2) == 0)
          add_text(" Text/HTML; charset=UTF-8", 1'b0);
        else
          add_junk($urandom_range(0, 12));
      end
      KIND_ENCODING: begin
        add_text("transfer-encoding", 1'b1);
        add_byte(K_COLON);
        repeat ($urandom_range(0, 3)) begin
          case ($urandom_range(0, 6))
            0, 1: add_text("chunked", 1'b1);
            2:    add_text("gzip, ", 1'b1);
            3:    add_text("c", 1'b1);
            4:    add_text("chunk ed", 1'b1);
            5:    add_byte(K_SP);
            default: add_junk(2);
          endcase
        end
      end
      KIND_NEAR: begin
        case ($urandom_range(0, 9))
          0: add_text("content-lengt", 1'b1);
          1: add_text("content-lengthh", 1'b1);
          2: add_text("content-types", 1'b1);
          3: add_text("transfer-encodin", 1'b1);
          4: add_text("c", 1'b1);
          5: add_text("t", 1'b1);
          6: add_text("tcontent-length", 1'b1);
          7: add_text("content-length ", 1'b1);
          8: add_text("transfer-encoding-x", 1'b1);
          default: begin
            // longer than the name counter can hold
            add_text("c", 1'b1);
            repeat ($urandom_range(30, 40)) add_byte("a" + 8'($urandom_range(0, 25)));
          end
        endcase
        add_byte(K_COLON);
        add_junk($urandom_range(0, 6));
      end
      KIND_OTHER: begin
        c = "a" + 8'($urandom_range(0, 25));
        while (c == "c" || c == "t")
          c = "a" + 8'($urandom_range(0, 25));
        add_text(string'(c), 1'b1);
        repeat ($urandom_range(0, 10)) begin
          if ($urandom_range(0, 5) == 0)
            add_byte("-");
          else
            add_text(string'(8'("a" + 8'($urandom_range(0, 25)))), 1'b1);
        end
        add_byte(K_COLON);
        add_junk($urandom_range(0, 10));
      end
      default: begin
        // noise: any first byte but CR or LF, a name free of CR and colon
        add_byte(rand_byte_but(K_CR, K_LF));
        repeat ($urandom_range(0, 15)) add_byte(rand_byte_but(K_CR, K_COLON));
        add_byte(K_COLON);
        add_junk($urandom_range(0, 8));
      end
    endcase
    add_line_end();
  endfunction

  // ---------------------------------------------------------------------------------------
  // Idle patterns
  // ---------------------------------------------------------------------------------------

  // Mostly no idle, often a short one, rarely a long one.
  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Run both sides flat out through one window of the stream.
  function automatic bit calm(int count);
    return count >= 700 && count < 850;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (n_fail < MAX_REPORTS)
      $display("mismatch on result %0d: %s got 0x%0h expected 0x%0h", n_checked, what, got, want);
    n_fail++;
  endtask

  // ---------------------------------------------------------------------------------------
  // Driver: offer pending bytes, predict each one as it is taken
  // ---------------------------------------------------------------------------------------
  int  send_gap = 0;
  bit  waiting_drain = 1'b0;

  always @(posedge clk) begin
    tx_item_t nxt_item;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predicted_q.push_back(parse_byte(in_byte_in));
        n_accepted <= n_accepted + 1;
      end
      if (in_valid && !in_ready) begin
        // hold the item until it is taken
      end else if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (waiting_drain) begin
        // both counts are settled here: nothing is on offer
        if (n_checked == n_accepted)
          waiting_drain = 1'b0;
        in_valid <= 1'b0;
      end else if (pending.size() > 0) begin
        nxt_item = pending.pop_front();
        if (nxt_item.pause) begin
          waiting_drain = 1'b1;
          in_valid <= 1'b0;
        end else begin
          in_valid   <= 1'b1;
          in_byte_in <= nxt_item.data;
          send_gap = calm(n_accepted) ? 0 : pick_idle();
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Monitor: take results, compare with the oldest prediction, pace out_ready
  // ---------------------------------------------------------------------------------------
  int stall_left = 0;
  int holdoff_left = 0;
  bit holdoff_done = 1'b0;

  always @(posedge clk) begin
    parse_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        n_checked <= n_checked + 1;
        if (predicted_q.size() == 0) begin
          report_mismatch("result with nothing owed", {28'd0, out_phase}, 32'd0);
        end else begin
          want = predicted_q.pop_front();
          if (out_phase !== want.phase)
            report_mismatch("phase", 32'(out_phase), 32'(want.phase));
          if (out_done_res !== want.done_res)
            report_mismatch("done_res", 32'(out_done_res), 32'(want.done_res));
          if (out_error !== want.error)
            report_mismatch("error", 32'(out_error), 32'(want.error));
          if (out_status_value !== want.status_value)
            report_mismatch("status_value", 32'(out_status_value), 32'(want.status_value));
          if (out_content_length !== want.content_length)
            report_mismatch("content_length", out_content_length, want.content_length);
          if (out_chunked !== want.chunked)
            report_mismatch("chunked", 32'(out_chunked), 32'(want.chunked));
          if (out_media_valid !== want.media_valid)
            report_mismatch("media_valid", 32'(out_media_valid), 32'(want.media_valid));
          if (out_media_char !== want.media_char)
            report_mismatch("media_char", 32'(out_media_char), 32'(want.media_char));
          if (out_media_end !== want.media_end)
            report_mismatch("media_end", 32'(out_media_end), 32'(want.media_end));
        end
      end
      // Once, hold off for a long stretch so the block fills and stalls its input.
      if (holdoff_left > 0) begin
        holdoff_left--;
        out_ready <= 1'b0;
      end else if (!holdoff_done && n_checked >= HOLDOFF_AT) begin
        holdoff_done = 1'b1;
        holdoff_left = HOLDOFF_LEN - 1;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        stall_left = calm(n_checked) ? 0 : pick_idle();
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stream, reset and end of run
  // ---------------------------------------------------------------------------------------
  initial begin
    int line_no;
    int r;
    // Status line: zero and all-ones bytes in the version, mixed case, and a status
    // that saturates and then stops at a non-digit.
    add_byte(8'h00);
    add_text("HTtP/1.1", 1'b0);
    add_byte(8'hFF);
    add_byte(K_SP);
    add_text("1234567x9", 1'b0);
    add_byte(K_SP);
    add_text("Ok", 1'b0);
    add_byte(K_CR);
    add_byte(K_LF);
    // drain the block before the header lines start
    add_pause();

    // Header lines: one of each kind first, then a weighted mix.
    line_no = 0;
    while (n_queued < TARGET_ITEMS - 30) begin
      if (line_no < NUM_KINDS) begin
        add_header_line(line_no);
      end else begin
        r = $urandom_range(0, 19);
        if (r < 4)       add_header_line(KIND_LENGTH);
        else if (r < 8)  add_header_line(KIND_TYPE);
        else if (r < 12) add_header_line(KIND_ENCODING);
        else if (r < 15) add_header_line(KIND_NEAR);
        else if (r < 18) add_header_line(KIND_OTHER);
        else             add_header_line(KIND_NOISE);
      end
      line_no++;
      if (line_no == 30)
        add_pause();
    end

    // Close the header with the exact CR LF CR LF, then feed bytes past the end.
    add_text("X-Last: 1", 1'b0);
    add_byte(K_CR);
    add_byte(K_LF);
    add_byte(K_CR);
    add_byte(K_LF);
    repeat (6) add_byte(8'($urandom_range(0, 255)));

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // every byte yields exactly one result
    while (n_checked < n_queued)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (predicted_q.size() != 0)
      report_mismatch("results never delivered", 32'(predicted_q.size()), 32'd0);
    if (n_fail == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  // Watchdog: several times the slowest correct run.
  initial begin
    #8ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
